// File: rtl/assert_macros.svh
// Assertion macros used by the checker in rtl/gscl_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, skip while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// File: rtl/gscl_pkg.sv
package gscl_pkg;

  // Field widths
  localparam int PosW    = 16;
  localparam int ChanW   = 8;
  localparam int WeightW = 15;

  // Divider shape: the quotient is a weight, below 2^QuotW.
  localparam int QuotW = 16;
  localparam int DenW  = PosW + 1;
  localparam int NumW  = DenW + QuotW;

  // Width of a blended channel sum before the divide by WeightOne
  localparam int SumW = ChanW + WeightW;

  localparam logic [WeightW-1:0] WeightOne = 15'd32767;

  // Command codes
  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [PosW-1:0]  stop_position;
    logic [ChanW-1:0] stop_red;
    logic [ChanW-1:0] stop_green;
    logic [ChanW-1:0] stop_blue;
    logic [ChanW-1:0] stop_alpha;
    logic [PosW-1:0]  sample_t;
  } gscl_in_t;

  typedef struct packed {
    logic [ChanW-1:0] mixed_red;
    logic [ChanW-1:0] mixed_green;
    logic [ChanW-1:0] mixed_blue;
    logic [ChanW-1:0] mixed_alpha;
    logic             has_stops;
    logic             gradient_valid;
  } gscl_out_t;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } gscl_entry_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } gscl_div_req_t;

endpackage

// File: rtl/gscl_divider.sv
module gscl_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gscl_pkg::gscl_div_req_t        req_i,
  output logic                           done_o,
  output logic [gscl_pkg::QuotW-1:0]     quot_o
);
  import gscl_pkg::*;

  // Restoring division, one quotient bit per cycle. The caller keeps
  // num below den * 2^QuotW, so the upper numerator bits start as remainder.
  localparam int CntW = $clog2(QuotW);
  localparam logic [CntW-1:0] StepLast = CntW'(QuotW - 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [QuotW-1:0] low_q;
  logic [QuotW-1:0] quot_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            ge;

  always_comb begin
    trial = {rem_q, low_q[QuotW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == StepLast);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num[NumW-1:QuotW];
      low_q <= req_i.num[QuotW-1:0];
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      low_q  <= {low_q[QuotW-2:0], 1'b0};
      quot_q <= {quot_q[QuotW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/gradient_stop_color_lookup.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | gscl_in_t  (cmd, stop, sample)
// out     | output    | out_valid_o / out_stall_i| gscl_out_t (mixed RGBA, flags)
//
// Clear and append give no result and leave the block ready for the next item. A query
// on an empty table goes straight to its result; one at or outside the end stops reads
// that stop, and one in the interior scans the stop memory, one read per cycle, for the
// right stop and then runs a serial division. rst_ni is asynchronous, active low; it
// empties the table, no clearing pass. A stalled result holds in the output
// register; the next item is accepted meanwhile and a query waits in StDone.
module gradient_stop_color_lookup #(
  parameter int MAX_STOPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gscl_pkg::gscl_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gscl_pkg::gscl_out_t out_o
);
  import gscl_pkg::*;

  localparam int IdxW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CntW = $clog2(MAX_STOPS + 1);
  localparam logic [CntW-1:0] CountFull = CntW'(MAX_STOPS);

  typedef enum logic [2:0] {
    StIdle,
    StFetch,
    StScan,
    StDiv,
    StMix,
    StFin,
    StDone
  } state_e;

  state_e state_q;

  // Table bookkeeping
  logic [CntW-1:0] count_q;
  logic [PosW-1:0] first_pos_q;
  logic [PosW-1:0] last_pos_q;

  // Stop memory, one synchronous read port, one write port
  gscl_entry_t     stop_mem_q [MAX_STOPS];
  gscl_entry_t     rdata_q;
  logic [IdxW-1:0] raddr;
  logic            mem_we;
  gscl_entry_t     wentry;

  // Query working registers
  logic [PosW-1:0]    t_q;
  logic [IdxW-1:0]    idx_q;
  gscl_entry_t        left_q;
  gscl_entry_t        right_q;
  logic [WeightW-1:0] w0_q, w1_q;
  logic [SumW-1:0]    sum_q [4];
  logic [ChanW-1:0]   res_q [4];

  // Output register
  logic      out_valid_q;
  gscl_out_t out_q;

  logic            accept;
  logic            is_append;
  logic            full;
  logic            q_first, q_last;
  logic [IdxW-1:0] last_idx;
  logic [CntW-1:0] last_cnt;
  logic [PosW-1:0] app_pos;
  logic            hit;
  logic            out_free;

  gscl_div_req_t     div_req;
  logic              div_done;
  logic [QuotW-1:0]  div_quot;
  logic [WeightW-1:0] w0_d;

  logic [PosW-1:0]  diff_rt, diff_d;
  logic [ChanW-1:0] cl [4];
  logic [ChanW-1:0] cr [4];
  logic [SumW-1:0]  sum_d [4];
  logic [ChanW-1:0] mix_d [4];

  assign accept    = in_valid_i && (state_q == StIdle);
  assign is_append = in_i.cmd == CmdAppend;
  assign full      = count_q == CountFull;
  assign last_cnt  = count_q - 1'b1;
  assign last_idx  = last_cnt[IdxW-1:0];
  assign out_free  = !out_valid_q || !out_stall_i;

  // End-stop decisions; the first stop wins when both apply.
  assign q_first = (count_q == CntW'(1)) || (in_i.sample_t <= first_pos_q);
  assign q_last  = in_i.sample_t >= last_pos_q;

  // Raise a non-monotonic append to the last stored position.
  assign app_pos = ((count_q != '0) && (last_pos_q > in_i.stop_position)) ?
                   last_pos_q : in_i.stop_position;

  always_comb begin
    mem_we       = accept && is_append && !full;
    wentry.pos   = app_pos;
    wentry.red   = in_i.stop_red;
    wentry.green = in_i.stop_green;
    wentry.blue  = in_i.stop_blue;
    wentry.alpha = in_i.stop_alpha;
  end

  // Read address: an end stop or the scan start on accept, then walk forward.
  always_comb begin
    unique case (state_q)
      StIdle:  raddr = (!q_first && q_last) ? last_idx : '0;
      StScan:  raddr = idx_q + 1'b1;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stop_mem_q[count_q[IdxW-1:0]] <= wentry;
    end
    rdata_q <= stop_mem_q[raddr];
  end

  // Scan hit: first stop at or above the sample. The left stop is in left_q.
  assign hit     = (state_q == StScan) && (rdata_q.pos >= t_q);
  assign diff_rt = rdata_q.pos - t_q;
  assign diff_d  = rdata_q.pos - left_q.pos;

  // num = 2*(r-t)*WeightOne + d, den = 2*d
  always_comb begin
    div_req.start = hit;
    div_req.num   = ({1'b0, diff_rt, {PosW{1'b0}}} - {{PosW{1'b0}}, diff_rt, 1'b0})
                    + {{(NumW-PosW){1'b0}}, diff_d};
    div_req.den   = {diff_d, 1'b0};
  end

  gscl_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Clamp the weight to full scale.
  assign w0_d = (div_quot > {1'b0, WeightOne}) ? WeightOne : div_quot[WeightW-1:0];

  always_comb begin
    cl[0] = left_q.red;   cr[0] = right_q.red;
    cl[1] = left_q.green; cr[1] = right_q.green;
    cl[2] = left_q.blue;  cr[2] = right_q.blue;
    cl[3] = left_q.alpha; cr[3] = right_q.alpha;
  end

  // Blend and divide by WeightOne = 2^15 - 1: x = a*2^15 + b gives
  // x / WeightOne = a + (a + b >= WeightOne), since a + b < 2 * WeightOne.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [ChanW-1:0] a;
      logic [WeightW-1:0] b;
      logic [WeightW:0] ab;
      logic [ChanW:0] q;
      sum_d[k] = ({{WeightW{1'b0}}, cl[k]} * {{ChanW{1'b0}}, w0_q})
               + ({{WeightW{1'b0}}, cr[k]} * {{ChanW{1'b0}}, w1_q})
               + {{ChanW{1'b0}}, WeightOne >> 1};
      a  = sum_q[k][SumW-1:WeightW];
      b  = sum_q[k][WeightW-1:0];
      ab = {{(WeightW+1-ChanW){1'b0}}, a} + {1'b0, b};
      q  = {1'b0, a} + {{ChanW{1'b0}}, (ab >= {1'b0, WeightOne})};
      mix_d[k] = q[ChanW] ? {ChanW{1'b1}} : q[ChanW-1:0];
    end
  end

  // Control: state, table bookkeeping, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Load a finished result, or drop the one just taken.
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            unique case (in_i.cmd)
              CmdClear: count_q <= '0;
              CmdAppend: begin
                if (!full) begin
                  count_q <= count_q + 1'b1;
                end
              end
              CmdQuery: begin
                priority if (count_q == '0) begin
                  state_q <= StDone;
                end else if (q_first || q_last) begin
                  state_q <= StFetch;
                end else begin
                  state_q <= StScan;
                end
              end
              default: ;
            endcase
          end
        end
        StFetch: state_q <= StDone;
        StScan: begin
          if (hit) begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) begin
            state_q <= StMix;
          end
        end
        StMix: state_q <= StFin;
        StFin: state_q <= StDone;
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      last_pos_q <= app_pos;
      if (count_q == '0) begin
        first_pos_q <= app_pos;
      end
    end
    unique case (state_q)
      StIdle: begin
        t_q   <= in_i.sample_t;
        idx_q <= '0;
        for (int k = 0; k < 4; k++) begin
          res_q[k] <= '0;
        end
      end
      StFetch: begin
        res_q[0] <= rdata_q.red;
        res_q[1] <= rdata_q.green;
        res_q[2] <= rdata_q.blue;
        res_q[3] <= rdata_q.alpha;
      end
      StScan: begin
        // Hold the left stop on a hit, advance otherwise.
        if (hit) begin
          right_q <= rdata_q;
        end else begin
          left_q <= rdata_q;
          idx_q  <= idx_q + 1'b1;
        end
      end
      StDiv: begin
        w0_q <= w0_d;
        w1_q <= WeightOne - w0_d;
      end
      StMix: begin
        for (int k = 0; k < 4; k++) begin
          sum_q[k] <= sum_d[k];
        end
      end
      StFin: begin
        for (int k = 0; k < 4; k++) begin
          res_q[k] <= mix_d[k];
        end
      end
      StDone: begin
        if (out_free) begin
          out_q.mixed_red      <= res_q[0];
          out_q.mixed_green    <= res_q[1];
          out_q.mixed_blue     <= res_q[2];
          out_q.mixed_alpha    <= res_q[3];
          out_q.has_stops      <= count_q != '0;
          out_q.gradient_valid <= count_q >= CntW'(2);
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/gscl_checker.sv
`include "assert_macros.svh"

module gscl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input gscl_pkg::gscl_in_t  in_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gscl_pkg::gscl_out_t out_o
);
  import gscl_pkg::*;

  logic in_acc;
  logic out_color_nz;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_color_nz = (out_o.mixed_red != '0) || (out_o.mixed_green != '0) ||
                        (out_o.mixed_blue != '0) || (out_o.mixed_alpha != '0);

  // A stalled result holds.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))

  // An accepted query moves the block out of StIdle, so that it stalls its input.
  `ASSERT_CLK(a_query_busy, clk_i, rst_ni, in_acc && (in_i.cmd == CmdQuery) |=> in_stall_o)

  // Clear, append and unused codes finish at once.
  `ASSERT_CLK(a_table_op_fast, clk_i, rst_ni, in_acc && (in_i.cmd != CmdQuery) |=> !in_stall_o)

  // An empty table gives a black, transparent result.
  `ASSERT_NEVER(a_empty_zero, clk_i, rst_ni, out_valid_o && !out_o.has_stops && out_color_nz)

  // Two stops imply at least one.
  `ASSERT_NEVER(a_flags_order, clk_i, rst_ni, out_valid_o && out_o.gradient_valid && !out_o.has_stops)

endmodule

bind gradient_stop_color_lookup gscl_checker u_gscl_checker (.*);
